[rtl/dhi_pkg.sv]
// ----------------------------------------------------------------------------
// dhi_pkg
// Shared types, constants and helpers for the difference-hash core.
// ----------------------------------------------------------------------------
package dhi_pkg;

  // Sampling grid: 9 columns by 8 rows gives 8 compares per row
  localparam int GRID_COLS = 9;
  localparam int GRID_ROWS = 8;
  localparam int HASH_W    = 64;

  // Configuration register fields
  localparam int CFG_DW  = 13;
  localparam int CFG_IW  = 2;

  // Reset values of the configuration registers
  localparam logic [CFG_DW-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_DW-1:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic              RST_COLOR_MODE   = 1'b1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_COLOR_MODE   = 2'd2
  } dhi_reg_t;

  // Configuration seen by the front
  typedef struct packed {
    logic [CFG_DW-1:0] frame_width;
    logic [CFG_DW-1:0] frame_height;
    logic              color_mode;
  } dhi_cfg_t;

  // One classified pixel: value, the cells it fills, end of frame
  typedef struct packed {
    logic [7:0]           pix;
    logic [GRID_ROWS-1:0] row_mask;
    logic [GRID_COLS-1:0] col_mask;
    logic                 last;
  } dhi_entry_t;

  // floor((a+b+c)/3) by reciprocal multiply, exact for sums up to 765
  function automatic logic [7:0] avg3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = 10'(a) + 10'(b) + 10'(c);
    prod = 20'(sum) * 20'd683;
    return prod[18:11];
  endfunction

endpackage

[rtl/dhi_front.sv]
// ----------------------------------------------------------------------------
// dhi_front
// Tracks the raster position, picks the grid cells a pixel fills and forms
// the pixel value; pushes one classified word per accepted pixel.
// ----------------------------------------------------------------------------
module dhi_front import dhi_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dhi_cfg_t   cfg,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_chan0,
  input  logic [7:0] in_chan1,
  input  logic [7:0] in_chan2,
  input  logic       in_frame_start,
  output logic       push,
  output dhi_entry_t push_entry
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int WH  = $clog2(MAX_HEIGHT + 1);
  localparam int PXW = $clog2(MAX_WIDTH);
  localparam int PYW = $clog2(MAX_HEIGHT);
  localparam int KW  = WW + 4;
  localparam int RW  = WH + 3;
  localparam int CXW = WW + 1;
  localparam int CYW = WH + 1;

  logic [PXW-1:0]       col_pos_r, col_pos_nxt;
  logic [PYW-1:0]       row_pos_r, row_pos_nxt;
  logic [WW-1:0]        w_eff;
  logic [WH-1:0]        h_eff;
  logic [PXW-1:0]       x_cur;
  logic [PYW-1:0]       y_cur;
  logic [KW-1:0]        x9;
  logic [KW-1:0]        kw;
  logic [RW-1:0]        jh;
  logic [GRID_COLS-1:0] col_mask;
  logic [GRID_ROWS-1:0] row_mask;
  logic                 end_row;
  logic                 end_frame;

  // Clamp the size registers: zero acts as one, oversize saturates
  always_comb begin
    if (cfg.frame_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      h_eff = WH'(1);
    end else if (32'(cfg.frame_height) > MAX_HEIGHT) begin
      h_eff = WH'(MAX_HEIGHT);
    end else begin
      h_eff = WH'(cfg.frame_height);
    end
  end

  // Position of this pixel; frame start forces the origin
  assign x_cur = in_frame_start ? '0 : col_pos_r;
  assign y_cur = in_frame_start ? '0 : row_pos_r;
  assign x9    = (KW'(x_cur) << 3) + KW'(x_cur);

  // Column k hits when 9x <= k*W < 9x+9, row j when (j*H)/8 == y
  always_comb begin
    kw       = '0;
    jh       = '0;
    col_mask = '0;
    row_mask = '0;
    for (int k = 0; k < GRID_COLS; k++) begin
      kw = KW'(w_eff) * KW'(k);
      col_mask[k] = (kw >= x9) && (kw < x9 + KW'(GRID_COLS));
    end
    for (int j = 0; j < GRID_ROWS; j++) begin
      jh = RW'(h_eff) * RW'(j);
      row_mask[j] = ((jh >> 3) == RW'(y_cur));
    end
  end

  assign end_row   = (CXW'(x_cur) + CXW'(1)) >= CXW'(w_eff);
  assign end_frame = end_row && ((CYW'(y_cur) + CYW'(1)) >= CYW'(h_eff));

  assign push_entry.pix      = cfg.color_mode ? avg3(in_chan0, in_chan1, in_chan2) : in_chan0;
  assign push_entry.row_mask = row_mask;
  assign push_entry.col_mask = col_mask;
  assign push_entry.last     = end_frame;
  assign push                = in_valid && !in_stall;

  // Advance the raster position on each accepted word
  always_comb begin
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    if (push) begin
      if (end_row) begin
        col_pos_nxt = '0;
        row_pos_nxt = end_frame ? '0 : y_cur + PYW'(1);
      end else begin
        col_pos_nxt = x_cur + PXW'(1);
        row_pos_nxt = y_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
    end
  end

endmodule

[rtl/dhi_queue.sv]
// ----------------------------------------------------------------------------
// dhi_queue
// Short first-in first-out buffer that decouples the front from the back.
// ----------------------------------------------------------------------------
module dhi_queue import dhi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  dhi_entry_t push_entry,
  output logic       full,
  output logic       pop_valid,
  output dhi_entry_t pop_entry,
  input  logic       pop
);

  dhi_entry_t          slots_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_r, count_nxt;
  logic                do_pop;

  assign full      = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_entry = slots_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QUEUE_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + QUEUE_CW'(push) - QUEUE_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[rtl/dhi_back.sv]
// ----------------------------------------------------------------------------
// dhi_back
// Writes sampled pixels into the 9x8 grid and, at the end of a frame,
// builds the 64-bit hash into the output register.
// ----------------------------------------------------------------------------
module dhi_back import dhi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  dhi_entry_t        q_entry,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HASH_W-1:0] out_hash_value
);

  logic [7:0]        grid_r   [GRID_ROWS][GRID_COLS];
  logic [7:0]        grid_nxt [GRID_ROWS][GRID_COLS];
  logic [HASH_W-1:0] hash_nxt;
  logic [HASH_W-1:0] hash_value_r;
  logic              out_valid_r, out_valid_nxt;
  logic              go;

  // Take a word when the output register is free or being emptied
  assign go    = q_valid && (!out_valid_r || !out_stall);
  assign q_pop = go;

  // Fill every cell that this pixel covers
  always_comb begin
    for (int j = 0; j < GRID_ROWS; j++) begin
      for (int k = 0; k < GRID_COLS; k++) begin
        grid_nxt[j][k] = (go && q_entry.row_mask[j] && q_entry.col_mask[k]) ?
                         q_entry.pix : grid_r[j][k];
      end
    end
  end

  // Compare each cell with its right neighbor
  always_comb begin
    for (int j = 0; j < GRID_ROWS; j++) begin
      for (int k = 0; k < GRID_COLS - 1; k++) begin
        hash_nxt[j*8 + k] = (grid_nxt[j][k] > grid_nxt[j][k+1]);
      end
    end
  end

  always_comb begin
    if (go && q_entry.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold grid and result; load the hash on the frame's last word
  always_ff @(posedge clk) begin
    grid_r <= grid_nxt;
    if (go && q_entry.last) begin
      hash_value_r <= hash_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = hash_value_r;

endmodule

[rtl/dhash_image_hash_core.sv]
// ----------------------------------------------------------------------------
// dhash_image_hash_core
// Streaming 64-bit difference hash over a 9x8 sampling grid of a frame.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  chan0, chan1, chan2, frame_start
//  out_     output     out_valid/out_stall  hash_value (64 bits)
//  cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data (13 bits)
//
//  One pixel per cycle sustained while out_stall is low; the four-word queue
//  and the output register set the pace; the hash loads on the last word's pop.
//  Reset (synchronous, rst_n low) loads 640, 480 and color mode, clears the
//  position and the queue; grid contents are undefined until a frame fills them.
//  A stalled output holds the back; the queue then fills and raises in_stall.
// ----------------------------------------------------------------------------
module dhash_image_hash_core import dhi_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_chan0,
  input  logic [7:0]        in_chan1,
  input  logic [7:0]        in_chan2,
  input  logic              in_frame_start,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HASH_W-1:0] out_hash_value,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  dhi_cfg_t   cfg_r;
  logic       push;
  dhi_entry_t push_entry;
  logic       q_full;
  logic       q_valid;
  dhi_entry_t q_entry;
  logic       q_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  // Configuration registers; unknown indexes drop the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= RST_FRAME_WIDTH;
      cfg_r.frame_height <= RST_FRAME_HEIGHT;
      cfg_r.color_mode   <= RST_COLOR_MODE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_data;
        REG_COLOR_MODE:   cfg_r.color_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dhi_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (q_full),
    .in_chan0       (in_chan0),
    .in_chan1       (in_chan1),
    .in_chan2       (in_chan2),
    .in_frame_start (in_frame_start),
    .push           (push),
    .push_entry     (push_entry)
  );

  dhi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry),
    .pop        (q_pop)
  );

  dhi_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

endmodule
